>>> rtl/xrng_pkg.sv
package xrng_pkg;

  localparam logic [63:0] DefaultState = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] OutMult      = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] SeedMult     = 64'hff51afd7ed558ccd;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    ReqSeed = 2'd0,
    ReqInt  = 2'd1,
    ReqReal = 2'd2,
    ReqNone = 2'd3
  } req_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    req_e        kind;
    logic [31:0] seed;
    logic [31:0] limit;
  } cmd_t;

  typedef enum logic [3:0] {
    StIdle, StSeedMul, StSeedMix, StStep, StMulLo, StMulHi, StCheck,
    StDiv, StDone
  } back_state_e;

  // One xorshift step on the state.
  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

endpackage

>>> rtl/xrng_front.sv
module xrng_front
  import xrng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] seed_value_i,
  input  logic [31:0] upper_limit_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t              fifo_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;
  cmd_t              cls;

  // Classify: a non-positive limit becomes a no-step request.
  always_comb begin
    cls.seed  = seed_value_i;
    cls.limit = upper_limit_i;
    case (req_type_i)
      ReqSeed: cls.kind = ReqSeed;
      ReqInt:  cls.kind = (upper_limit_i[31] || upper_limit_i == '0) ? ReqNone : ReqInt;
      ReqReal: cls.kind = ReqReal;
      default: cls.kind = ReqNone;
    endcase
  end

  assign in_ready_o  = (cnt_q != (PtrW+1)'(QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  // Hold queued transactions.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cls;
    end
  end

  // Advance pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

>>> rtl/xrng_back.sv
module xrng_back
  import xrng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [52:0] random_value_o
);

  back_state_e state_q, state_d;
  logic [63:0] gen_q, gen_d;
  cmd_t        cmd_q, cmd_d;
  logic [63:0] acc_q, acc_d;     // product / value under work
  logic [63:0] rem_q, rem_d;     // remainder for divide
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  steps_q, steps_d;
  logic [32:0] rej_q, rej_d;     // 2^32 mod limit
  logic        pass_q, pass_d;   // 0: reject bound, 1: final mod
  logic [52:0] res_q, res_d;
  logic        ovld_q, ovld_d;
  logic [63:0] mul_lo, mul_hi;
  logic [32:0] trial;
  logic [32:0] rem_sh;

  // 32x32 partial products of the output multiply.
  assign mul_lo = {32'd0, gen_q[31:0]} * {32'd0, OutMult[31:0]};
  assign mul_hi = {32'd0, gen_q[31:0]} * {32'd0, OutMult[63:32]}
                + {32'd0, gen_q[63:32]} * {32'd0, OutMult[31:0]};

  // Restoring divide step: one quotient bit per cycle.
  assign rem_sh = {rem_q[31:0], acc_q[63]};
  assign trial  = rem_sh - {1'b0, cmd_q.limit};

  assign cmd_ready_o    = (state_q == StIdle) && !ovld_q;
  assign out_valid_o    = ovld_q;
  assign random_value_o = res_q;

  always_comb begin
    state_d = state_q; gen_d = gen_q; cmd_d = cmd_q; acc_d = acc_q;
    rem_d = rem_q; cnt_d = cnt_q; steps_d = steps_q; rej_d = rej_q;
    pass_d = pass_q; res_d = res_q; ovld_d = ovld_q;
    if (ovld_q && out_ready_i) ovld_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i && !ovld_q) begin
          cmd_d = cmd_i;
          case (cmd_i.kind)
            ReqSeed: state_d = StSeedMul;
            ReqInt: begin
              // Compute 2^32 mod limit first.
              acc_d   = {32'd1, 32'd0};
              rem_d   = '0;
              cnt_d   = 6'd0;
              pass_d  = 1'b0;
              state_d = StDiv;
            end
            ReqReal: state_d = StStep;
            default: begin
              res_d = '0; ovld_d = 1'b1;
            end
          endcase
        end
      end
      StSeedMul: begin
        // Seed times multiplier, low 64 bits, in StSeedMul and then StSeedMix.
        acc_d   = {32'd0, cmd_q.seed} * {32'd0, SeedMult[31:0]};
        state_d = StSeedMix;
      end
      StSeedMix: begin
        logic [63:0] s;
        s = DefaultState ^ {acc_q[63:32] + cmd_q.seed * SeedMult[63:32], acc_q[31:0]};
        gen_d   = (s == '0) ? DefaultState : s;
        steps_d = 2'd0;
        state_d = StStep;
      end
      StStep: begin
        gen_d = xs_step(gen_q);
        if (cmd_q.kind == ReqSeed) begin
          steps_d = steps_q + 1'b1;
          if (steps_q == 2'd3) begin
            res_d = '0; ovld_d = 1'b1; state_d = StIdle;
          end
        end else begin
          state_d = StMulLo;
        end
      end
      StMulLo: begin
        acc_d   = mul_lo;
        rem_d   = mul_hi;
        state_d = StMulHi;
      end
      StMulHi: begin
        acc_d   = {acc_q[63:32] + rem_q[31:0], acc_q[31:0]};
        state_d = StCheck;
      end
      StCheck: begin
        if (cmd_q.kind == ReqReal) begin
          res_d = acc_q[63:11]; ovld_d = 1'b1; state_d = StIdle;
        end else if ({1'b0, acc_q[63:32]} < rej_q) begin
          state_d = StStep;
        end else begin
          acc_d   = {acc_q[63:32], 32'd0};
          rem_d   = '0;
          cnt_d   = 6'd0;
          pass_d  = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        // 33 dividend bits for 2^32, 32 for the sample.
        acc_d = {acc_q[62:0], 1'b0};
        rem_d = trial[32] ? {31'd0, rem_sh} : {31'd0, trial};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (pass_q ? 6'd31 : 6'd32)) state_d = StDone;
      end
      StDone: begin
        if (!pass_q) begin
          rej_d   = rem_q[32:0];
          acc_d   = {acc_q[0], acc_q[63:1]};
          state_d = StStep;
        end else begin
          res_d = {21'd0, rem_q[31:0]}; ovld_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Shift for 2^32 starts with bit 32 at the top after one pre-shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      gen_q   <= DefaultState;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      gen_q   <= gen_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    acc_q   <= (state_q == StIdle && state_d == StDiv) ? {31'd0, 1'b1, 32'd0} << 31 : acc_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    steps_q <= steps_d;
    rej_q   <= rej_d;
    pass_q  <= pass_d;
    res_q   <= res_d;
  end

endmodule

>>> rtl/xorshift64star_bounded_rng.sv
// Bounded xorshift64* generator. Each request gives one result. An integer
// request runs two bit-serial 32-bit divisions, of 33 and 32 dividend bits,
// and each rejection retry repeats the step, multiply and check states. The
// queue registers each request in front of the back end. The back end takes
// nothing in the cycle in which a result is still held. The back-end sequencer
// drives a one-bit-per-cycle divider. A two-entry queue lets requests be
// accepted while the back end is busy.
module xorshift64star_bounded_rng
  import xrng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // seed_value[31:0], upper_limit[63:32]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata  // random_value[52:0], zero pad
);

  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [52:0] random_value;

  xrng_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .seed_value_i (s_axis_tdata[31:0]),
    .upper_limit_i(s_axis_tdata[63:32]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  xrng_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .random_value_o(random_value)
  );

  assign m_axis_tdata = {3'd0, random_value};

endmodule

>>> rtl/xrng_checker.sv
module xrng_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // Pad bits stay zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:53] == 3'd0) else $error("pad");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("hold");

  // No result in the cycle after reset.
  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid) else $error("reset");

  // Empty block takes input straight out of reset.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> s_axis_tready) else $error("ready");

endmodule

bind xorshift64star_bounded_rng xrng_checker u_chk (.*);

>>> verif/tb_xorshift64star_bounded_rng.sv
module tb_xorshift64star_bounded_rng;
  import xrng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  // Generator state as the block should hold it
  logic [63:0] model_state;
  logic [52:0] expected_values[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          timed_out;

  xorshift64star_bounded_rng i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the model state and return the scrambled output
  function automatic logic [63:0] next_output();
    logic [63:0] s;
    s = model_state;
    s = s ^ (s >> 12);
    s = s ^ (s << 25);
    s = s ^ (s >> 27);
    model_state = s;
    return s * 64'h2545f4914f6cdd1d;
  endfunction

  // Work out the value a request should return, updating the model state
  function automatic logic [52:0] predict_value(req_e kind, logic [31:0] seed,
                                                logic [31:0] limit);
    logic [63:0] tmp;
    logic [31:0] reject;
    logic [31:0] v;
    logic [52:0] res;
    res = '0;
    case (kind)
      ReqSeed: begin
        tmp = 64'h9e3779b97f4a7c15 ^ ({32'd0, seed} * 64'hff51afd7ed558ccd);
        model_state = (tmp == 64'd0) ? 64'h9e3779b97f4a7c15 : tmp;
        repeat (4) tmp = next_output();
      end
      ReqInt: begin
        if (limit != 32'd0 && !limit[31]) begin
          reject = 32'((64'h1_0000_0000) % {32'd0, limit});
          do begin
            tmp = next_output();
            v = tmp[63:32];
          end while (v < reject);
          res = 53'(v % limit);
        end
      end
      ReqReal: begin
        tmp = next_output();
        res = tmp[63:11];
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Offer one request and hold it until the transaction completes
  task automatic send_request(req_e kind, logic [31:0] seed, logic [31:0] limit);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {limit, seed};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_values.push_back(predict_value(kind, seed, limit));
  endtask

  // Compare every result against the oldest expected value
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_axis_tdata[52:0]);
        error_count++;
      end else begin
        if (m_axis_tdata[52:0] !== expected_values[0]) begin
          $display("%0t: random_value expected %h actual %h", $time,
                   expected_values[0], m_axis_tdata[52:0]);
          error_count++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_request(ReqReal, 32'd0, 32'd0);
    send_request(ReqInt, 32'd0, 32'd10);
    send_request(ReqSeed, 32'd0, 32'hffffffff);
    send_request(ReqReal, 32'hffffffff, 32'hffffffff);
    send_request(ReqSeed, 32'hffffffff, 32'd0);
    send_request(ReqInt, 32'd0, 32'd1);
    send_request(ReqInt, 32'd0, 32'd0);
    send_request(ReqInt, 32'd0, 32'h80000000);
    send_request(ReqInt, 32'd0, 32'hffffffff);
    send_request(ReqInt, 32'd0, 32'h7fffffff);
    // large odd limit forces frequent rejection
    send_request(ReqInt, 32'd0, 32'h60000001);
    send_request(ReqInt, 32'd0, 32'h40000001);
    send_request(ReqInt, 32'd0, 32'h80000001);
    send_request(ReqNone, 32'hffffffff, 32'h7fffffff);
    send_request(ReqReal, 32'd0, 32'd0);
    send_request(ReqSeed, 32'h12345678, 32'd0);
    send_request(ReqInt, 32'hffffffff, 32'd3);
    send_request(ReqInt, 32'd0, 32'h00010000);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned pick;
    logic [31:0] limit;
    repeat (count) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: limit = $urandom;
        1: limit = $urandom_range(1, 100);
        2: limit = {1'b0, 31'($urandom)};
        default: limit = 32'h7fffffff - $urandom_range(0, 3);
      endcase
      if (pick < 8) send_request(ReqSeed, $urandom, $urandom);
      else if (pick < 55) send_request(ReqInt, $urandom, limit);
      else if (pick < 95) send_request(ReqReal, $urandom, $urandom);
      else send_request(ReqNone, $urandom, $urandom);
    end
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                           int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    test_random(count);
  endtask

  initial begin
    model_state    = 64'h9e3779b97f4a7c15;
    error_count    = 0;
    idle_cycles    = 0;
    timed_out      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ReqSeed;
    m_axis_tready  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    run_phase(0, 0, 110);
    run_phase(82, 0, 110);
    run_phase(0, 82, 110);
    run_phase(11, 11, 110);
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
